// ===== rtl/core/sm83alu_pkg.sv =====
// sm83alu_pkg: shared types, operation codes and constants for the sm83 alu
// used by sm83alu_exec and sm83_alu_with_flags_core; depends on nothing
`default_nettype none

package sm83alu_pkg;

   // flag bit positions inside the packed z n h c nibble
   localparam int unsigned FLAG_Z = 3;
   localparam int unsigned FLAG_N = 2;
   localparam int unsigned FLAG_H = 1;
   localparam int unsigned FLAG_C = 0;

   // decimal adjust constants
   localparam logic [7:0] DAA_LIMIT  = 8'h99;
   localparam logic [7:0] DAA_ADJ_HI = 8'h60;
   localparam logic [7:0] DAA_ADJ_LO = 8'h06;
   localparam logic [3:0] DAA_DIGIT  = 4'd9;

   typedef enum logic [5:0] {
      OP_ADD   = 6'd0,
      OP_ADC   = 6'd1,
      OP_SUB   = 6'd2,
      OP_SBC   = 6'd3,
      OP_AND   = 6'd4,
      OP_XOR   = 6'd5,
      OP_OR    = 6'd6,
      OP_CP    = 6'd7,
      OP_INC   = 6'd8,
      OP_DEC   = 6'd9,
      OP_RLCA  = 6'd10,
      OP_RRCA  = 6'd11,
      OP_RLA   = 6'd12,
      OP_RRA   = 6'd13,
      OP_DAA   = 6'd14,
      OP_CPL   = 6'd15,
      OP_SCF   = 6'd16,
      OP_CCF   = 6'd17,
      OP_RLC   = 6'd18,
      OP_RRC   = 6'd19,
      OP_RL    = 6'd20,
      OP_RR    = 6'd21,
      OP_SLA   = 6'd22,
      OP_SRA   = 6'd23,
      OP_SWAP  = 6'd24,
      OP_SRL   = 6'd25,
      OP_BIT   = 6'd26,
      OP_RES   = 6'd27,
      OP_SET   = 6'd28,
      OP_ADD16 = 6'd29,
      OP_ADDSP = 6'd30,
      OP_INC16 = 6'd31,
      OP_DEC16 = 6'd32
   } alu_op_type;

   typedef struct packed {
      logic [5:0]  mode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/sm83_alu_with_flags_core.sv =====
// sm83_alu_with_flags_core: top level of the sm83 alu, input and result registers
// depends on sm83alu_pkg and sm83alu_exec
//
// usage
//  - request channel: drive req_data and raise start for one cycle per beat;
//    a beat is taken at any rising edge where start is high and busy is low
//  - busy is held low, so a new beat may be offered in every cycle
//  - result channel: rsp_valid marks rsp_data for exactly one cycle; the
//    receiver must take it then, there is no way to hold results back
//  - timing: the beat is registered at the accepting edge, the datapath
//    works between the input register and the result register, and the
//    result is shown once the result register has captured it
//  - throughput: one beat per cycle, limited only by the single-pass
//    datapath between the two register stages
//  - reset (synchronous, active high) clears both valid bits; beats in
//    flight are dropped and no result appears until a new beat is taken
//  - no state is kept between beats; undefined operation codes give a zero
//    result with the incoming flags passed through
`default_nettype none

module sm83_alu_with_flags_core
   import sm83alu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   logic    accept;
   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;
   req_type req_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   rsp_type exec_rsp;

   // never stalls: the datapath takes a beat every cycle
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // input register stage
   assign req_valid_in = accept;
   assign req_in       = accept ? req_data : req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_ff <= req_in;
   end

   sm83alu_exec u_exec (
      .req_i (req_ff),
      .rsp_o (exec_rsp)
   );

   // result register, strobe is the delayed input valid
   assign rsp_valid_in = req_valid_ff;
   assign rsp_in       = req_valid_ff ? exec_rsp : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/sm83alu_exec.sv =====
// sm83alu_exec: combinational datapath for one sm83 alu operation
// depends on sm83alu_pkg for the beat types and operation codes
`default_nettype none

module sm83alu_exec
   import sm83alu_pkg::*;
(
   input  req_type req_i,
   output rsp_type rsp_o
);

   alu_op_type  op;
   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic [3:0]  fin;
   logic        carry_t;
   logic [8:0]  sum9;
   logic [4:0]  hsum5;
   logic [8:0]  diff9;
   logic [4:0]  hdiff5;
   logic [7:0]  inc8;
   logic [7:0]  dec8;
   logic [7:0]  bit_mask;
   logic        daa_hi;
   logic        daa_lo;
   logic [7:0]  daa_adj;
   logic [7:0]  daa_res;
   logic [16:0] sum17;
   logic [12:0] hsum13;
   logic [15:0] sp_sum;
   logic [4:0]  sp_h5;
   logic [8:0]  sp_c9;
   logic [7:0]  r8;
   logic [15:0] res;
   logic [3:0]  flg;

   assign op  = alu_op_type'(req_i.mode);
   assign a   = req_i.operand_a[7:0];
   assign b   = req_i.operand_b[7:0];
   assign fin = req_i.flags_in;
   assign cin = fin[FLAG_C];

   // carry/borrow in only for adc and sbc
   assign carry_t = ((op == OP_ADC) || (op == OP_SBC)) ? cin : 1'b0;

   assign sum9   = {1'b0, a} + {1'b0, b} + {8'h00, carry_t};
   assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, carry_t};
   assign diff9  = {1'b0, a} - {1'b0, b} - {8'h00, carry_t};
   assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, carry_t};
   assign inc8   = a + 8'd1;
   assign dec8   = a - 8'd1;

   assign bit_mask = 8'd1 << req_i.bit_index;

   // decimal adjust: after subtraction only the incoming h and c decide
   assign daa_hi  = cin | (~fin[FLAG_N] & (a > DAA_LIMIT));
   assign daa_lo  = fin[FLAG_H] | (~fin[FLAG_N] & (a[3:0] > DAA_DIGIT));
   assign daa_adj = (daa_hi ? DAA_ADJ_HI : 8'h00) | (daa_lo ? DAA_ADJ_LO : 8'h00);
   assign daa_res = fin[FLAG_N] ? (a - daa_adj) : (a + daa_adj);

   assign sum17  = {1'b0, req_i.operand_a} + {1'b0, req_i.operand_b};
   assign hsum13 = {1'b0, req_i.operand_a[11:0]} + {1'b0, req_i.operand_b[11:0]};

   // sp plus signed byte, flags come from the unsigned low byte add
   assign sp_sum = req_i.operand_a + {{8{b[7]}}, b};
   assign sp_h5  = {1'b0, req_i.operand_a[3:0]} + {1'b0, b[3:0]};
   assign sp_c9  = {1'b0, req_i.operand_a[7:0]} + {1'b0, b};

   always_comb begin
      r8  = 8'h00;
      res = 16'h0000;
      flg = fin;
      case (op)
         OP_ADD, OP_ADC: begin
            r8  = sum9[7:0];
            flg = {(sum9[7:0] == 8'h00), 1'b0, hsum5[4], sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            r8  = (op == OP_CP) ? a : diff9[7:0];
            flg = {(diff9[7:0] == 8'h00), 1'b1, hdiff5[4], diff9[8]};
         end
         OP_AND: begin
            r8  = a & b;
            flg = {((a & b) == 8'h00), 1'b0, 1'b1, 1'b0};
         end
         OP_XOR: begin
            r8  = a ^ b;
            flg = {((a ^ b) == 8'h00), 3'b000};
         end
         OP_OR: begin
            r8  = a | b;
            flg = {((a | b) == 8'h00), 3'b000};
         end
         OP_INC: begin
            r8  = inc8;
            flg = {(inc8 == 8'h00), 1'b0, (a[3:0] == 4'hF), cin};
         end
         OP_DEC: begin
            r8  = dec8;
            flg = {(dec8 == 8'h00), 1'b1, (a[3:0] == 4'h0), cin};
         end
         OP_RLCA: begin
            r8  = {a[6:0], a[7]};
            flg = {3'b000, a[7]};
         end
         OP_RRCA: begin
            r8  = {a[0], a[7:1]};
            flg = {3'b000, a[0]};
         end
         OP_RLA: begin
            r8  = {a[6:0], cin};
            flg = {3'b000, a[7]};
         end
         OP_RRA: begin
            r8  = {cin, a[7:1]};
            flg = {3'b000, a[0]};
         end
         OP_DAA: begin
            r8  = daa_res;
            flg = {(daa_res == 8'h00), fin[FLAG_N], 1'b0, daa_hi};
         end
         OP_CPL: begin
            r8  = ~a;
            flg = {fin[FLAG_Z], 1'b1, 1'b1, cin};
         end
         OP_SCF: begin
            r8  = a;
            flg = {fin[FLAG_Z], 1'b0, 1'b0, 1'b1};
         end
         OP_CCF: begin
            r8  = a;
            flg = {fin[FLAG_Z], 1'b0, 1'b0, ~cin};
         end
         OP_RLC: begin
            r8  = {a[6:0], a[7]};
            flg = {(a == 8'h00), 2'b00, a[7]};
         end
         OP_RRC: begin
            r8  = {a[0], a[7:1]};
            flg = {(a == 8'h00), 2'b00, a[0]};
         end
         OP_RL: begin
            r8  = {a[6:0], cin};
            flg = {({a[6:0], cin} == 8'h00), 2'b00, a[7]};
         end
         OP_RR: begin
            r8  = {cin, a[7:1]};
            flg = {({cin, a[7:1]} == 8'h00), 2'b00, a[0]};
         end
         OP_SLA: begin
            r8  = {a[6:0], 1'b0};
            flg = {(a[6:0] == 7'h00), 2'b00, a[7]};
         end
         OP_SRA: begin
            r8  = {a[7], a[7:1]};
            flg = {(a[7:1] == 7'h00), 2'b00, a[0]};
         end
         OP_SWAP: begin
            r8  = {a[3:0], a[7:4]};
            flg = {(a == 8'h00), 3'b000};
         end
         OP_SRL: begin
            r8  = {1'b0, a[7:1]};
            flg = {(a[7:1] == 7'h00), 2'b00, a[0]};
         end
         OP_BIT: begin
            r8  = a;
            flg = {((a & bit_mask) == 8'h00), 1'b0, 1'b1, cin};
         end
         OP_RES: begin
            r8 = a & ~bit_mask;
         end
         OP_SET: begin
            r8 = a | bit_mask;
         end
         default: begin
            r8 = 8'h00;
         end
      endcase

      // wide operations override the zero-extended byte result
      case (op)
         OP_ADD16: begin
            res = sum17[15:0];
            flg = {fin[FLAG_Z], 1'b0, hsum13[12], sum17[16]};
         end
         OP_ADDSP: begin
            res = sp_sum;
            flg = {2'b00, sp_h5[4], sp_c9[8]};
         end
         OP_INC16: begin
            res = req_i.operand_a + 16'd1;
         end
         OP_DEC16: begin
            res = req_i.operand_a - 16'd1;
         end
         default: begin
            res = {8'h00, r8};
         end
      endcase
   end

   assign rsp_o.result    = res;
   assign rsp_o.flags_out = flg;

endmodule

`default_nettype wire
